// ===== hdl/cpt_pkg.sv =====
// Shared constants and types for the closest-point-on-triangle core.
// No dependencies; imported by cpt_mul, the core and the testbench.
`timescale 1ns / 1ps

package cpt_pkg;

  // Default coordinate width (Q16.16 at 32)
  localparam int DEF_COORD_BITS = 32;

  // Multiplier digit width: one digit of the multiplier per pipeline stage
  localparam int MUL_DIGIT = 8;

  typedef enum logic [2:0] {
    RG_A     = 3'd0,
    RG_B     = 3'd1,
    RG_C     = 3'd2,
    RG_AB    = 3'd3,
    RG_AC    = 3'd4,
    RG_BC    = 3'd5,
    RG_FACE  = 3'd6,
    RG_DEGEN = 3'd7
  } region_t;

endpackage

// ===== hdl/cpt_mul.sv =====
// Pipelined signed multiplier, one multiplier digit per stage.
// Depends on cpt_pkg (MUL_DIGIT).
`timescale 1ns / 1ps

module cpt_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [AW-1:0]        a,
  input  logic signed [BW-1:0]        b,
  output logic signed [AW+BW-1:0]     p
);
  import cpt_pkg::*;

  localparam int ND  = (BW + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int BX  = ND * MUL_DIGIT;
  localparam int ACW = AW + BX;
  localparam int PPW = AW + MUL_DIGIT + 1;

  logic signed [AW-1:0]  a_s [0:ND-1];
  logic        [BX-1:0]  b_s [0:ND-1];
  logic signed [ACW-1:0] acc [0:ND];

  assign a_s[0] = a;
  assign b_s[0] = BX'(b);
  assign acc[0] = '0;

  for (genvar i = 0; i < ND; i++) begin : g_stage
    logic signed [MUL_DIGIT:0] dig;
    logic signed [PPW-1:0]     pp;

    // low digits are unsigned, the top digit carries the sign
    assign dig = $signed({((i == ND - 1) ? b_s[i][i*MUL_DIGIT + MUL_DIGIT - 1] : 1'b0),
                          b_s[i][i*MUL_DIGIT +: MUL_DIGIT]});
    assign pp  = a_s[i] * dig;

    always_ff @(posedge clk) begin
      if (en) begin
        acc[i+1] <= acc[i] + (ACW'(pp) <<< (MUL_DIGIT * i));
      end
    end

    if (i < ND - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          a_s[i+1] <= a_s[i];
          b_s[i+1] <= b_s[i];
        end
      end
    end
  end

  assign p = acc[ND][AW+BW-1:0];

endmodule

// ===== hdl/cpt_div.sv =====
// Pipelined signed divider, truncating toward zero, one quotient bit per stage.
// No package dependency. Caller keeps den nonzero.
`timescale 1ns / 1ps

module cpt_div #(
  parameter int NW = 171,
  parameter int DW = 139
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic signed [NW-1:0] quo
);

  logic [NW-1:0] nq [0:NW];
  logic [DW-1:0] rm [0:NW-1];
  logic [DW-1:0] dv [0:NW-1];
  logic          ng [0:NW];
  logic [NW-1:0] qm;

  // magnitudes in, sign of the quotient travels alongside
  always_ff @(posedge clk) begin
    if (en) begin
      nq[0] <= num[NW-1] ? -num : num;
      dv[0] <= den[DW-1] ? -den : den;
      rm[0] <= '0;
      ng[0] <= num[NW-1] ^ den[DW-1];
    end
  end

  // numerator bits are consumed MSB first and replaced by quotient bits
  for (genvar i = 0; i < NW; i++) begin : g_step
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [NW-1:0] nq_n;

    assign trial = {rm[i], nq[i][NW-1-i]};
    assign diff  = trial - {1'b0, dv[i]};
    assign ge    = trial >= {1'b0, dv[i]};

    always_comb begin
      nq_n = nq[i];
      nq_n[NW-1-i] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq[i+1] <= nq_n;
        ng[i+1] <= ng[i];
      end
    end

    if (i < NW - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          rm[i+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
          dv[i+1] <= dv[i];
        end
      end
    end
  end

  assign qm = nq[NW];

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= ng[NW] ? -qm : qm;
    end
  end

endmodule

// ===== hdl/closest_point_on_triangle_core.sv =====
// Closest point on a triangle (vertex / edge / face regions), fully pipelined.
// Throughput: one item per cycle unless out_valid waits on out_ready, which stalls
// the whole pipeline; depth is set by the bit-per-stage dividers.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
// Depends on cpt_pkg, cpt_mul, cpt_div.
`timescale 1ns / 1ps

module closest_point_on_triangle_core #(
  parameter int COORD_BITS = cpt_pkg::DEF_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  input  logic signed [COORD_BITS-1:0] vert_a_x,
  input  logic signed [COORD_BITS-1:0] vert_a_y,
  input  logic signed [COORD_BITS-1:0] vert_a_z,
  input  logic signed [COORD_BITS-1:0] vert_b_x,
  input  logic signed [COORD_BITS-1:0] vert_b_y,
  input  logic signed [COORD_BITS-1:0] vert_b_z,
  input  logic signed [COORD_BITS-1:0] vert_c_x,
  input  logic signed [COORD_BITS-1:0] vert_c_y,
  input  logic signed [COORD_BITS-1:0] vert_c_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] near_x,
  output logic signed [COORD_BITS-1:0] near_y,
  output logic signed [COORD_BITS-1:0] near_z,
  output logic [2:0]                   region
);
  import cpt_pkg::*;

  localparam int W    = COORD_BITS;
  localparam int DFW  = W + 1;          // vertex differences
  localparam int DOTW = 2 * W + 4;      // d1..d6
  localparam int VW   = 4 * W + 9;      // va, vb, vc
  localparam int DENW = 4 * W + 11;     // divisor
  localparam int NUMW = 5 * W + 11;     // dividend

  localparam int L1 = (DFW + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int L2 = (DOTW + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int L3 = L1;
  localparam int LD = NUMW + 2;

  localparam int IDX1 = L1 + 1;          // dot products
  localparam int IDX2 = IDX1 + L2 + 1;   // cross terms
  localparam int IDX3 = IDX2 + 1;        // region select
  localparam int IDX4 = IDX3 + L3 + 1;   // dividend
  localparam int IDXQ = IDX4 + LD;       // quotient
  localparam int TOT  = IDXQ + 2;

  localparam int GW  = 9 * W + 9 * DFW;
  localparam int RBW = 3 + 3 * W;
  localparam int RBL = L3 + 1 + LD;

  localparam int P2L [6] = '{0, 2, 4, 0, 2, 4};
  localparam int P2R [6] = '{3, 1, 1, 5, 5, 3};

  logic            en;
  logic [TOT-1:0]  vld;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[TOT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOT-2:0], in_valid};
    end
  end

  // ---------------- stage 0: differences ----------------
  logic signed [W-1:0]   pin [3];
  logic signed [W-1:0]   ain [3];
  logic signed [W-1:0]   bin [3];
  logic signed [W-1:0]   cin [3];
  logic signed [DFW-1:0] s0_ab [3];
  logic signed [DFW-1:0] s0_ac [3];
  logic signed [DFW-1:0] s0_bc [3];
  logic signed [DFW-1:0] s0_ap [3];
  logic signed [DFW-1:0] s0_bp [3];
  logic signed [DFW-1:0] s0_cp [3];
  logic signed [W-1:0]   s0_a [3];
  logic signed [W-1:0]   s0_b [3];
  logic signed [W-1:0]   s0_c [3];

  assign pin = '{point_x, point_y, point_z};
  assign ain = '{vert_a_x, vert_a_y, vert_a_z};
  assign bin = '{vert_b_x, vert_b_y, vert_b_z};
  assign cin = '{vert_c_x, vert_c_y, vert_c_z};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s0_ab[k] <= DFW'(bin[k]) - DFW'(ain[k]);
        s0_ac[k] <= DFW'(cin[k]) - DFW'(ain[k]);
        s0_bc[k] <= DFW'(cin[k]) - DFW'(bin[k]);
        s0_ap[k] <= DFW'(pin[k]) - DFW'(ain[k]);
        s0_bp[k] <= DFW'(pin[k]) - DFW'(bin[k]);
        s0_cp[k] <= DFW'(pin[k]) - DFW'(cin[k]);
        s0_a[k]  <= ain[k];
        s0_b[k]  <= bin[k];
        s0_c[k]  <= cin[k];
      end
    end
  end

  // geometry rides along to the region select
  logic [GW-1:0] gm [0:IDX2];

  always_comb begin
    gm[0] = '0;
    for (int k = 0; k < 3; k++) begin
      gm[0][k*W +: W]                   = s0_a[k];
      gm[0][3*W + k*W +: W]             = s0_b[k];
      gm[0][6*W + k*W +: W]             = s0_c[k];
      gm[0][9*W + k*DFW +: DFW]         = s0_ab[k];
      gm[0][9*W + 3*DFW + k*DFW +: DFW] = s0_ac[k];
      gm[0][9*W + 6*DFW + k*DFW +: DFW] = s0_bc[k];
    end
  end

  for (genvar i = 0; i < IDX2; i++) begin : g_gm
    always_ff @(posedge clk) begin
      if (en) gm[i+1] <= gm[i];
    end
  end

  // ---------------- dot products ----------------
  logic signed [2*DFW-1:0] m1 [6][3];
  logic signed [DOTW-1:0]  s1_d [6];

  for (genvar j = 0; j < 6; j++) begin : g_dot
    for (genvar k = 0; k < 3; k++) begin : g_c
      logic signed [DFW-1:0] lhs;
      logic signed [DFW-1:0] rhs;
      assign lhs = (j % 2 == 0) ? s0_ab[k] : s0_ac[k];
      assign rhs = (j / 2 == 0) ? s0_ap[k] : ((j / 2 == 1) ? s0_bp[k] : s0_cp[k]);
      cpt_mul #(.AW(DFW), .BW(DFW)) u_mul (
        .clk(clk), .en(en), .a(lhs), .b(rhs), .p(m1[j][k])
      );
    end
    always_ff @(posedge clk) begin
      if (en) s1_d[j] <= DOTW'(m1[j][0]) + DOTW'(m1[j][1]) + DOTW'(m1[j][2]);
    end
  end

  logic [6*DOTW-1:0] dd [0:L2+1];

  always_comb begin
    for (int j = 0; j < 6; j++) dd[0][j*DOTW +: DOTW] = s1_d[j];
  end

  for (genvar i = 0; i <= L2; i++) begin : g_dd
    always_ff @(posedge clk) begin
      if (en) dd[i+1] <= dd[i];
    end
  end

  // ---------------- cross terms ----------------
  logic signed [2*DOTW-1:0] m2 [6];
  logic signed [VW-1:0]     s2_va;
  logic signed [VW-1:0]     s2_vb;
  logic signed [VW-1:0]     s2_vc;

  for (genvar j = 0; j < 6; j++) begin : g_cross
    cpt_mul #(.AW(DOTW), .BW(DOTW)) u_mul (
      .clk(clk), .en(en), .a(s1_d[P2L[j]]), .b(s1_d[P2R[j]]), .p(m2[j])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_vc <= VW'(m2[0]) - VW'(m2[1]);
      s2_vb <= VW'(m2[2]) - VW'(m2[3]);
      s2_va <= VW'(m2[4]) - VW'(m2[5]);
    end
  end

  // ---------------- region select ----------------
  logic signed [DOTW-1:0] d [6];
  logic signed [W-1:0]    ga [3];
  logic signed [W-1:0]    gb [3];
  logic signed [W-1:0]    gc [3];
  logic signed [DFW-1:0]  gab [3];
  logic signed [DFW-1:0]  gac [3];
  logic signed [DFW-1:0]  gbc [3];

  always_comb begin
    for (int j = 0; j < 6; j++) d[j] = dd[L2+1][j*DOTW +: DOTW];
    for (int k = 0; k < 3; k++) begin
      ga[k]  = gm[IDX2][k*W +: W];
      gb[k]  = gm[IDX2][3*W + k*W +: W];
      gc[k]  = gm[IDX2][6*W + k*W +: W];
      gab[k] = gm[IDX2][9*W + k*DFW +: DFW];
      gac[k] = gm[IDX2][9*W + 3*DFW + k*DFW +: DFW];
      gbc[k] = gm[IDX2][9*W + 6*DFW + k*DFW +: DFW];
    end
  end

  logic signed [DOTW:0]   e43, e56, den_ab, den_ac;
  logic signed [DOTW+1:0] den_bc;
  logic signed [DENW-1:0] den_f;
  logic c_a, c_b, c_ab, c_c, c_ac, c_bc;

  assign e43    = d[3] - d[2];
  assign e56    = d[4] - d[5];
  assign den_ab = d[0] - d[2];
  assign den_ac = d[1] - d[5];
  assign den_bc = (DOTW+2)'(e43) + (DOTW+2)'(e56);
  assign den_f  = DENW'(s2_va) + DENW'(s2_vb) + DENW'(s2_vc);

  assign c_a  = (d[0][DOTW-1] || d[0] == '0) && (d[1][DOTW-1] || d[1] == '0);
  assign c_b  = !d[2][DOTW-1] && (e43[DOTW] || e43 == '0);
  assign c_ab = (s2_vc[VW-1] || s2_vc == '0) && !d[0][DOTW-1]
                && (d[2][DOTW-1] || d[2] == '0);
  assign c_c  = !d[5][DOTW-1] && (e56[DOTW] || e56 == '0);
  assign c_ac = (s2_vb[VW-1] || s2_vb == '0) && !d[1][DOTW-1]
                && (d[5][DOTW-1] || d[5] == '0);
  assign c_bc = (s2_va[VW-1] || s2_va == '0) && !e43[DOTW] && !e56[DOTW];

  region_t               rg_n;
  logic signed [W-1:0]   base_n [3];
  logic signed [DFW-1:0] x1_n [3];
  logic signed [DFW-1:0] x2_n [3];
  logic signed [VW-1:0]  y1_n, y2_n;
  logic signed [DENW-1:0] den_n;

  always_comb begin
    rg_n  = RG_A;
    y1_n  = '0;
    y2_n  = '0;
    den_n = DENW'(1);
    for (int k = 0; k < 3; k++) begin
      base_n[k] = ga[k];
      x1_n[k]   = '0;
      x2_n[k]   = '0;
    end
    priority if (c_a) begin
      rg_n = RG_A;
    end else if (c_b) begin
      rg_n = RG_B;
      for (int k = 0; k < 3; k++) base_n[k] = gb[k];
    end else if (c_ab) begin
      if (den_ab == '0) begin
        rg_n = RG_DEGEN;
      end else begin
        rg_n  = RG_AB;
        y1_n  = VW'(d[0]);
        den_n = DENW'(den_ab);
        for (int k = 0; k < 3; k++) x1_n[k] = gab[k];
      end
    end else if (c_c) begin
      rg_n = RG_C;
      for (int k = 0; k < 3; k++) base_n[k] = gc[k];
    end else if (c_ac) begin
      if (den_ac == '0) begin
        rg_n = RG_DEGEN;
      end else begin
        rg_n  = RG_AC;
        y1_n  = VW'(d[1]);
        den_n = DENW'(den_ac);
        for (int k = 0; k < 3; k++) x1_n[k] = gac[k];
      end
    end else if (c_bc) begin
      if (den_bc == '0) begin
        rg_n = RG_DEGEN;
      end else begin
        rg_n  = RG_BC;
        y1_n  = VW'(e43);
        den_n = DENW'(den_bc);
        for (int k = 0; k < 3; k++) begin
          base_n[k] = gb[k];
          x1_n[k]   = gbc[k];
        end
      end
    end else begin
      if (den_f == '0) begin
        rg_n = RG_DEGEN;
      end else begin
        rg_n  = RG_FACE;
        y1_n  = s2_vb;
        y2_n  = s2_vc;
        den_n = den_f;
        for (int k = 0; k < 3; k++) begin
          x1_n[k] = gab[k];
          x2_n[k] = gac[k];
        end
      end
    end
  end

  region_t               s3_rg;
  logic signed [W-1:0]   s3_base [3];
  logic signed [DFW-1:0] s3_x1 [3];
  logic signed [DFW-1:0] s3_x2 [3];
  logic signed [VW-1:0]  s3_y1, s3_y2;
  logic signed [DENW-1:0] s3_den;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_rg  <= rg_n;
      s3_y1  <= y1_n;
      s3_y2  <= y2_n;
      s3_den <= den_n;
      for (int k = 0; k < 3; k++) begin
        s3_base[k] <= base_n[k];
        s3_x1[k]   <= x1_n[k];
        s3_x2[k]   <= x2_n[k];
      end
    end
  end

  // ---------------- dividend ----------------
  logic signed [VW+DFW-1:0] m3a [3];
  logic signed [VW+DFW-1:0] m3b [3];
  logic signed [NUMW-1:0]   s4_num [3];
  logic signed [DENW-1:0]   s4_den;
  logic [DENW-1:0]          dn [0:L3];

  for (genvar k = 0; k < 3; k++) begin : g_num
    cpt_mul #(.AW(VW), .BW(DFW)) u_mul_a (
      .clk(clk), .en(en), .a(s3_y1), .b(s3_x1[k]), .p(m3a[k])
    );
    cpt_mul #(.AW(VW), .BW(DFW)) u_mul_b (
      .clk(clk), .en(en), .a(s3_y2), .b(s3_x2[k]), .p(m3b[k])
    );
    always_ff @(posedge clk) begin
      if (en) s4_num[k] <= NUMW'(m3a[k]) + NUMW'(m3b[k]);
    end
  end

  assign dn[0] = s3_den;

  for (genvar i = 0; i < L3; i++) begin : g_dn
    always_ff @(posedge clk) begin
      if (en) dn[i+1] <= dn[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) s4_den <= dn[L3];
  end

  // region and base point wait for the quotient
  logic [RBW-1:0] rb [0:RBL];

  assign rb[0] = {s3_base[2], s3_base[1], s3_base[0], s3_rg};

  for (genvar i = 0; i < RBL; i++) begin : g_rb
    always_ff @(posedge clk) begin
      if (en) rb[i+1] <= rb[i];
    end
  end

  // ---------------- division and output ----------------
  logic signed [NUMW-1:0] q [3];
  region_t                q_rg;
  logic signed [W-1:0]    q_base [3];

  for (genvar k = 0; k < 3; k++) begin : g_div
    cpt_div #(.NW(NUMW), .DW(DENW)) u_div (
      .clk(clk), .en(en), .num(s4_num[k]), .den(s4_den), .quo(q[k])
    );
  end

  always_comb begin
    q_rg = region_t'(rb[RBL][2:0]);
    for (int k = 0; k < 3; k++) q_base[k] = rb[RBL][3 + k*W +: W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      near_x <= q_base[0] + q[0][W-1:0];
      near_y <= q_base[1] + q[1][W-1:0];
      near_z <= q_base[2] + q[2][W-1:0];
      region <= q_rg;
    end
  end

  // ---------------- assertions ----------------
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    vld[IDX3] |-> s3_den != '0)
    else $error("zero divisor reached the divider");

  a_vertex_no_offset: assert property (@(posedge clk) disable iff (rst)
    vld[IDXQ] && (q_rg == RG_A || q_rg == RG_B || q_rg == RG_C || q_rg == RG_DEGEN)
      |-> (q[0] == '0 && q[1] == '0 && q[2] == '0))
    else $error("vertex or degenerate result carries a nonzero offset");

  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

// ===== test/closest_point_on_triangle_core_tb.sv =====
// Testbench for closest_point_on_triangle_core: a directed table, then random queries.
// Every result is checked against a wide-integer Voronoi-region predictor.
// Depends on cpt_pkg and the core RTL.
`timescale 1ns / 1ps

module closest_point_on_triangle_core_tb;
  import cpt_pkg::*;

  localparam int W          = 32;
  localparam int NUM_RANDOM = 550;
  localparam int DRAIN_WAIT = 250;   // longer than the core's pipeline
  localparam int WDOG_LIMIT = 4000;
  localparam int LONG_HOLD  = 600;
  localparam logic signed [W-1:0] U = 32'sh0001_0000;   // 1.0 in Q16.16

  typedef logic signed [W-1:0]  coord_t;
  typedef logic signed [255:0]  wide_t;
  typedef struct { coord_t p[3]; coord_t a[3]; coord_t b[3]; coord_t c[3]; } query_t;
  typedef struct { coord_t n[3]; region_t rg; } nearest_t;
  typedef struct { query_t q; bit known; nearest_t want; } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid;
  coord_t point_x = '0, point_y = '0, point_z = '0;
  coord_t vert_a_x = '0, vert_a_y = '0, vert_a_z = '0;
  coord_t vert_b_x = '0, vert_b_y = '0, vert_b_z = '0;
  coord_t vert_c_x = '0, vert_c_y = '0, vert_c_z = '0;
  coord_t near_x, near_y, near_z;
  logic [2:0] region;

  nearest_t nearest_q[$];
  int errors = 0;
  int results_seen = 0;
  int queries_sent = 0;
  int region_hits[8];
  int idle_cycles = 0;
  bit hold_req = 0;
  bit no_idle = 0;

  closest_point_on_triangle_core #(.COORD_BITS(W)) i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .vert_a_x(vert_a_x), .vert_a_y(vert_a_y), .vert_a_z(vert_a_z),
    .vert_b_x(vert_b_x), .vert_b_y(vert_b_y), .vert_b_z(vert_b_z),
    .vert_c_x(vert_c_x), .vert_c_y(vert_c_y), .vert_c_z(vert_c_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .near_x(near_x), .near_y(near_y), .near_z(near_z), .region(region)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic wide_t dot3(wide_t x[3], wide_t y[3]);
    return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
  endfunction

  // base + trunc(edge*num/den) per axis; zero-length edge falls back to A
  function automatic nearest_t edge_point(nearest_t r, wide_t base[3], wide_t edv[3],
                                          wide_t num, wide_t den, region_t rg);
    wide_t t;
    if (den == 0) return r;
    for (int k = 0; k < 3; k++) begin
      t = base[k] + (edv[k] * num) / den;
      r.n[k] = t[W-1:0];
    end
    r.rg = rg;
    return r;
  endfunction

  function automatic nearest_t closest_point(query_t q);
    wide_t p[3], a[3], b[3], c[3], ab[3], ac[3], ap[3], bp[3], cp[3], bc[3];
    wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, den, t;
    nearest_t r;
    for (int k = 0; k < 3; k++) begin
      p[k] = q.p[k]; a[k] = q.a[k]; b[k] = q.b[k]; c[k] = q.c[k];
      ab[k] = b[k] - a[k]; ac[k] = c[k] - a[k]; bc[k] = c[k] - b[k];
      ap[k] = p[k] - a[k]; bp[k] = p[k] - b[k]; cp[k] = p[k] - c[k];
      r.n[k] = q.a[k];
    end
    r.rg = RG_DEGEN;
    d1 = dot3(ab, ap);
    d2 = dot3(ac, ap);
    if (d1 <= 0 && d2 <= 0) begin
      r.rg = RG_A;
      return r;
    end
    d3 = dot3(ab, bp);
    d4 = dot3(ac, bp);
    if (d3 >= 0 && d4 - d3 <= 0) begin
      r.n = q.b;
      r.rg = RG_B;
      return r;
    end
    vc = d1 * d4 - d3 * d2;
    if (vc <= 0 && d1 >= 0 && d3 <= 0) return edge_point(r, a, ab, d1, d1 - d3, RG_AB);
    d5 = dot3(ab, cp);
    d6 = dot3(ac, cp);
    if (d6 >= 0 && d5 - d6 <= 0) begin
      r.n = q.c;
      r.rg = RG_C;
      return r;
    end
    vb = d5 * d2 - d1 * d6;
    if (vb <= 0 && d2 >= 0 && d6 <= 0) return edge_point(r, a, ac, d2, d2 - d6, RG_AC);
    va = d3 * d6 - d5 * d4;
    if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0)
      return edge_point(r, b, bc, d4 - d3, (d4 - d3) + (d5 - d6), RG_BC);
    den = va + vb + vc;
    if (den == 0) return r;
    for (int k = 0; k < 3; k++) begin
      t = a[k] + (ab[k] * vb + ac[k] * vc) / den;
      r.n[k] = t[W-1:0];
    end
    r.rg = RG_FACE;
    return r;
  endfunction

  function automatic query_t mkq(coord_t px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz);
    query_t q;
    q.p = '{px, py, pz}; q.a = '{ax, ay, az}; q.b = '{bx, by, bz}; q.c = '{cx, cy, cz};
    return q;
  endfunction

  function automatic nearest_t mkn(coord_t x, y, z, region_t rg);
    nearest_t n;
    n.n = '{x, y, z};
    n.rg = rg;
    return n;
  endfunction

  function automatic bit same_nearest(nearest_t x, nearest_t y);
    return x.n[0] == y.n[0] && x.n[1] == y.n[1] && x.n[2] == y.n[2] && x.rg == y.rg;
  endfunction

  function automatic coord_t rand_coord(int mode);
    if (mode < 6) return coord_t'(int'($urandom_range(0, 2097152)) - 1048576);
    if (mode < 8) return coord_t'($urandom);
    return coord_t'(int'($urandom_range(0, 6)) - 3);   // tiny: ties and flat triangles
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      q.p[k] = rand_coord(mode); q.a[k] = rand_coord(mode);
      q.b[k] = rand_coord(mode); q.c[k] = rand_coord(mode);
    end
    return q;
  endfunction

  // Drive at the falling edge, hold until the transfer, leave at the next falling edge.
  task automatic send_query(query_t q);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    {point_x, point_y, point_z} = {q.p[0], q.p[1], q.p[2]};
    {vert_a_x, vert_a_y, vert_a_z} = {q.a[0], q.a[1], q.a[2]};
    {vert_b_x, vert_b_y, vert_b_z} = {q.b[0], q.b[1], q.b[2]};
    {vert_c_x, vert_c_y, vert_c_z} = {q.c[0], q.c[1], q.c[2]};
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    nearest_q.insert(nearest_q.size(), closest_point(q));
    queries_sent++;
    @(negedge clk);
  endtask

  // Receiver: random stall per result, one long hold-off on request
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        stall = LONG_HOLD;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 15);
      end
      repeat (stall) begin
        out_ready = 1'b0;
        @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    nearest_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      region_hits[region]++;
      if (nearest_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %h %h %h region %0d",
                                   near_x, near_y, near_z, region);
      end else begin
        want = nearest_q.pop_front();
        if (near_x !== want.n[0] || near_y !== want.n[1] || near_z !== want.n[2] ||
            region !== want.rg) begin
          errors++;
          if (errors <= 10)
            $display("mismatch #%0d: exp %h %h %h rg %0d, got %h %h %h rg %0d",
                     results_seen, want.n[0], want.n[1], want.n[2], want.rg,
                     near_x, near_y, near_z, region);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    nearest_t got;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // unit right triangle in z=0, points in each region, plus other triangles
    rw.known = 1; rw.q = mkq(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    rw.want = mkn(0, 0, 0, RG_A); rows.insert(rows.size(), rw);
    rw.q = mkq(-U, -U, 0, 0, 0, 0, U, 0, 0, 0, U, 0);
    rw.want = mkn(0, 0, 0, RG_A); rows.insert(rows.size(), rw);
    rw.q = mkq(2 * U, 0, 0, 0, 0, 0, U, 0, 0, 0, U, 0);
    rw.want = mkn(U, 0, 0, RG_B); rows.insert(rows.size(), rw);
    rw.q = mkq(0, 2 * U, 0, 0, 0, 0, U, 0, 0, 0, U, 0);
    rw.want = mkn(0, U, 0, RG_C); rows.insert(rows.size(), rw);
    rw.q = mkq(U, U, U, U, U, U, 2 * U, U, U, U, 2 * U, U);   // P on A: tie
    rw.want = mkn(U, U, U, RG_A); rows.insert(rows.size(), rw);
    rw.q = mkq(U / 2, U, 0, 0, 0, 0, 0, 0, 0, U, 0, 0);       // A == B
    rw.want = mkn(0, 0, 0, RG_DEGEN); rows.insert(rows.size(), rw);
    rw.known = 0;
    rows.insert(rows.size(), '{mkq(U / 2, -U, 0, 0, 0, 0, U, 0, 0, 0, U, 0), 0, rw.want});
    rows.insert(rows.size(), '{mkq(-U, U / 2, 0, 0, 0, 0, U, 0, 0, 0, U, 0), 0, rw.want});
    rows.insert(rows.size(), '{mkq(U, U, 0, 0, 0, 0, U, 0, 0, 0, U, 0), 0, rw.want});
    rows.insert(rows.size(), '{mkq(U / 4, U / 4, U, 0, 0, 0, U, 0, 0, 0, U, 0), 0,
                               rw.want});
    rows.insert(rows.size(), '{mkq(U / 2, U, 0, 0, 0, 0, U, 0, 0, 2 * U, 0, 0), 0,
                               rw.want});
    rows.insert(rows.size(), '{mkq(U, U, 0, 0, 0, 0, U, 0, 0, 0, 0, 0), 0, rw.want});
    rows.insert(rows.size(), '{mkq(U, U, 0, U, 0, 0, U, 0, 0, 0, U, 0), 0, rw.want});
    rows.insert(rows.size(), '{mkq('1, '1, '1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                         32'sh7fffffff, 32'sh80000000, 0, 0, 32'sh7fffffff, 32'sh80000000),
                     0, rw.want});
    rows.insert(rows.size(), '{mkq(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                         32'sh80000000, 32'sh80000000, 32'sh80000000,
                         32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                         32'sh80000000, 32'sh7fffffff, 32'sh80000000), 0, rw.want});
    rows.insert(rows.size(), '{mkq(32'sh80000000, 32'sh80000000, 32'sh80000000,
                         32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                         32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                         32'sh7fffffff, 32'sh80000000, 32'sh7fffffff), 0, rw.want});
    rows.insert(rows.size(), '{mkq(0, 0, 32'sh7fffffff, 0, 0, 0, 32'sh7fffffff, 0, 0,
                         0, 32'sh7fffffff, 0), 0, rw.want});

    foreach (rows[i]) begin
      if (rows[i].known) begin
        got = closest_point(rows[i].q);
        if (!same_nearest(got, rows[i].want)) begin
          errors++;
          if (errors <= 10) $display("table row %0d: predictor disagrees with typed value", i);
        end
      end
      send_query(rows[i].q);
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 150) hold_req = 1;
      if (i == 300) begin
        in_valid = 1'b0;
        while (nearest_q.size() != 0) @(negedge clk);
      end
      no_idle = (i >= 400 && i < 460);
      send_query(rand_query());
    end
    in_valid = 1'b0;
    no_idle = 0;

    while (nearest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("sent %0d queries, checked %0d results", queries_sent, results_seen);
    $display("regions A/B/C %0d/%0d/%0d, edges %0d/%0d/%0d, face %0d, degenerate %0d",
             region_hits[0], region_hits[1], region_hits[2], region_hits[3],
             region_hits[4], region_hits[5], region_hits[6], region_hits[7]);
    if (errors == 0 && nearest_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("errors: %0d, results missing: %0d", errors, nearest_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/cpt_pkg.sv
hdl/cpt_mul.sv
hdl/cpt_div.sv
hdl/closest_point_on_triangle_core.sv
test/closest_point_on_triangle_core_tb.sv
